FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checkers of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge once reset is released
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: design/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Types, widths and helpers of the box pair collision resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = 20;
    localparam int SHIFT_BITS = 24;
    localparam int N_STAGES   = 6;

    localparam int SUM_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
    localparam int D_BITS   = SUM_BITS + 1;
    localparam int OV_BITS  = D_BITS + 1;
    localparam int SH_BITS  = OV_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [SIZE_BITS-1:0]  size_t;
    typedef logic        [SIZE_BITS:0]    wsum_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [D_BITS-1:0]     diff_t;
    typedef logic        [D_BITS-1:0]     mag_t;
    typedef logic signed [OV_BITS-1:0]    ov_t;
    typedef logic signed [SH_BITS-1:0]    sh_t;
    typedef logic signed [SHIFT_BITS-1:0] shift_t;

    typedef struct packed {
        coord_t a_left;
        coord_t a_top;
        size_t  a_width;
        size_t  a_height;
        logic   a_fixed;
        coord_t b_left;
        coord_t b_top;
        size_t  b_width;
        size_t  b_height;
        logic   b_fixed;
    } pair_t;

    typedef struct packed {
        logic   hit;
        logic   axis_vertical;
        shift_t a_shift_x;
        shift_t a_shift_y;
        shift_t b_shift_x;
        shift_t b_shift_y;
        logic   a_grounded;
        logic   b_grounded;
    } result_t;

    typedef struct packed {
        logic [N_STAGES-1:0] load;
    } pipe_ctrl_t;

    function automatic shift_t sat_shift(sh_t v);
        shift_t r;
        if ((&v[SH_BITS-1:SHIFT_BITS-1]) || !(|v[SH_BITS-1:SHIFT_BITS-1])) begin
            r = v[SHIFT_BITS-1:0];
        end
        else if (v[SH_BITS-1]) begin
            r = {1'b1, {(SHIFT_BITS-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(SHIFT_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: design/aabb_core.sv
// ----------------------------------------------------------------------------
// aabb_core
// Six-stage datapath: edges and doubled centers, hit test, center distance,
// overlap per axis, axis choice, shift split and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_core (
    input  logic                clk,
    input  aabb_pkg::pipe_ctrl_t ctrl,
    input  aabb_pkg::pair_t     pair,
    output aabb_pkg::result_t   res
);

    typedef struct packed {
        aabb_pkg::sum_t   a_right;
        aabb_pkg::sum_t   b_right;
        aabb_pkg::sum_t   a_bottom;
        aabb_pkg::sum_t   b_bottom;
        aabb_pkg::sum_t   cxa;
        aabb_pkg::sum_t   cxb;
        aabb_pkg::sum_t   cya;
        aabb_pkg::sum_t   cyb;
        aabb_pkg::coord_t a_left;
        aabb_pkg::coord_t a_top;
        aabb_pkg::coord_t b_left;
        aabb_pkg::coord_t b_top;
        aabb_pkg::wsum_t  wx;
        aabb_pkg::wsum_t  wy;
        logic             a_fixed;
        logic             b_fixed;
    } st1_t;

    typedef struct packed {
        logic             hit;
        aabb_pkg::diff_t  dx;
        aabb_pkg::diff_t  dy;
        aabb_pkg::wsum_t  wx;
        aabb_pkg::wsum_t  wy;
        logic             a_fixed;
        logic             b_fixed;
    } st2_t;

    typedef struct packed {
        logic             hit;
        aabb_pkg::mag_t   adx;
        aabb_pkg::mag_t   ady;
        logic             pos_x;
        logic             pos_y;
        aabb_pkg::wsum_t  wx;
        aabb_pkg::wsum_t  wy;
        logic             a_fixed;
        logic             b_fixed;
    } st3_t;

    typedef struct packed {
        logic             hit;
        aabb_pkg::ov_t    ovx;
        aabb_pkg::ov_t    ovy;
        logic             pos_x;
        logic             pos_y;
        logic             a_fixed;
        logic             b_fixed;
    } st4_t;

    typedef struct packed {
        logic             hit;
        logic             vert;
        aabb_pkg::ov_t    ov;
        logic             pos;
        logic             a_fixed;
        logic             b_fixed;
    } st5_t;

    st1_t              s1_reg, s1_next;
    st2_t              s2_reg, s2_next;
    st3_t              s3_reg, s3_next;
    st4_t              s4_reg, s4_next;
    st5_t              s5_reg, s5_next;
    aabb_pkg::result_t s6_reg, s6_next;

    always_comb
    begin
        s1_next.a_left   = pair.a_left;
        s1_next.a_top    = pair.a_top;
        s1_next.b_left   = pair.b_left;
        s1_next.b_top    = pair.b_top;
        s1_next.a_right  = aabb_pkg::sum_t'(pair.a_left) + aabb_pkg::sum_t'(pair.a_width);
        s1_next.b_right  = aabb_pkg::sum_t'(pair.b_left) + aabb_pkg::sum_t'(pair.b_width);
        s1_next.a_bottom = aabb_pkg::sum_t'(pair.a_top) + aabb_pkg::sum_t'(pair.a_height);
        s1_next.b_bottom = aabb_pkg::sum_t'(pair.b_top) + aabb_pkg::sum_t'(pair.b_height);
        s1_next.cxa = (aabb_pkg::sum_t'(pair.a_left) <<< 1) + aabb_pkg::sum_t'(pair.a_width);
        s1_next.cxb = (aabb_pkg::sum_t'(pair.b_left) <<< 1) + aabb_pkg::sum_t'(pair.b_width);
        s1_next.cya = (aabb_pkg::sum_t'(pair.a_top) <<< 1) + aabb_pkg::sum_t'(pair.a_height);
        s1_next.cyb = (aabb_pkg::sum_t'(pair.b_top) <<< 1) + aabb_pkg::sum_t'(pair.b_height);
        s1_next.wx  = aabb_pkg::wsum_t'(pair.a_width) + aabb_pkg::wsum_t'(pair.b_width);
        s1_next.wy  = aabb_pkg::wsum_t'(pair.a_height) + aabb_pkg::wsum_t'(pair.b_height);
        s1_next.a_fixed = pair.a_fixed;
        s1_next.b_fixed = pair.b_fixed;
    end

    always_comb
    begin
        s2_next.hit = !((s1_reg.a_right  < aabb_pkg::sum_t'(s1_reg.b_left)) ||
                        (s1_reg.b_right  < aabb_pkg::sum_t'(s1_reg.a_left)) ||
                        (s1_reg.a_bottom < aabb_pkg::sum_t'(s1_reg.b_top))  ||
                        (s1_reg.b_bottom < aabb_pkg::sum_t'(s1_reg.a_top)));
        s2_next.dx  = aabb_pkg::diff_t'(s1_reg.cxb) - aabb_pkg::diff_t'(s1_reg.cxa);
        s2_next.dy  = aabb_pkg::diff_t'(s1_reg.cyb) - aabb_pkg::diff_t'(s1_reg.cya);
        s2_next.wx  = s1_reg.wx;
        s2_next.wy  = s1_reg.wy;
        s2_next.a_fixed = s1_reg.a_fixed;
        s2_next.b_fixed = s1_reg.b_fixed;
    end

    always_comb
    begin
        s3_next.hit   = s2_reg.hit;
        s3_next.adx   = s2_reg.dx[aabb_pkg::D_BITS-1] ? aabb_pkg::mag_t'(-s2_reg.dx)
                                                      : aabb_pkg::mag_t'(s2_reg.dx);
        s3_next.ady   = s2_reg.dy[aabb_pkg::D_BITS-1] ? aabb_pkg::mag_t'(-s2_reg.dy)
                                                      : aabb_pkg::mag_t'(s2_reg.dy);
        s3_next.pos_x = !s2_reg.dx[aabb_pkg::D_BITS-1] && (s2_reg.dx != '0);
        s3_next.pos_y = !s2_reg.dy[aabb_pkg::D_BITS-1] && (s2_reg.dy != '0);
        s3_next.wx    = s2_reg.wx;
        s3_next.wy    = s2_reg.wy;
        s3_next.a_fixed = s2_reg.a_fixed;
        s3_next.b_fixed = s2_reg.b_fixed;
    end

    always_comb
    begin
        s4_next.hit   = s3_reg.hit;
        s4_next.ovx   = aabb_pkg::ov_t'(s3_reg.wx) - aabb_pkg::ov_t'(s3_reg.adx);
        s4_next.ovy   = aabb_pkg::ov_t'(s3_reg.wy) - aabb_pkg::ov_t'(s3_reg.ady);
        s4_next.pos_x = s3_reg.pos_x;
        s4_next.pos_y = s3_reg.pos_y;
        s4_next.a_fixed = s3_reg.a_fixed;
        s4_next.b_fixed = s3_reg.b_fixed;
    end

    always_comb
    begin
        s5_next.hit  = s4_reg.hit;
        s5_next.vert = !(s4_reg.ovx < s4_reg.ovy);
        s5_next.ov   = s5_next.vert ? s4_reg.ovy : s4_reg.ovx;
        s5_next.pos  = s5_next.vert ? s4_reg.pos_y : s4_reg.pos_x;
        s5_next.a_fixed = s4_reg.a_fixed;
        s5_next.b_fixed = s4_reg.b_fixed;
    end

    aabb_pkg::sh_t sov;
    aabb_pkg::sh_t ash;
    aabb_pkg::sh_t bsh;

    always_comb
    begin
        sov = s5_reg.pos ? aabb_pkg::sh_t'(s5_reg.ov) : -aabb_pkg::sh_t'(s5_reg.ov);
        ash = '0;
        bsh = '0;
        if (!s5_reg.a_fixed && !s5_reg.b_fixed) begin
            ash = -sov;
            bsh = sov;
        end
        else if (!s5_reg.a_fixed) begin
            ash = -(sov <<< 1);
        end
        else if (!s5_reg.b_fixed) begin
            bsh = sov <<< 1;
        end

        s6_next = '0;
        if (s5_reg.hit) begin
            s6_next.hit           = 1'b1;
            s6_next.axis_vertical = s5_reg.vert;
            if (s5_reg.vert) begin
                s6_next.a_shift_y  = aabb_pkg::sat_shift(ash);
                s6_next.b_shift_y  = aabb_pkg::sat_shift(bsh);
                s6_next.a_grounded = s5_reg.pos;
                s6_next.b_grounded = !s5_reg.pos;
            end
            else begin
                s6_next.a_shift_x = aabb_pkg::sat_shift(ash);
                s6_next.b_shift_x = aabb_pkg::sat_shift(bsh);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0]) s1_reg <= s1_next;
        if (ctrl.load[1]) s2_reg <= s2_next;
        if (ctrl.load[2]) s3_reg <= s3_next;
        if (ctrl.load[3]) s4_reg <= s4_next;
        if (ctrl.load[4]) s5_reg <= s5_next;
        if (ctrl.load[5]) s6_reg <= s6_next;
    end

    assign res = s6_reg;

endmodule

FILE: design/aabb_collision_resolve_top.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolve_top
// Box pair collision resolver: hit test, minimum overlap axis, shift split.
// ----------------------------------------------------------------------------
// Input channel pair_valid / pair_stall / pair carries one pair of boxes per
// transfer; output channel res_valid / res_stall / res returns one result per
// pair, in order.
// The input transfer itself loads the first of the six register stages of
// the datapath.
// Throughput: one pair per cycle, sustained while res is not stalled.
// Each stage holds a valid bit and advances when the stage after it is empty
// or advancing, so bubbles are squeezed out and the last stage is the output
// register. A stall on res holds the result and fills the stages behind it;
// pair_stall rises only once all six stages hold pairs.
// Reset clears all valid bits; no result is shown until a new pair enters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_collision_resolve_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  aabb_pkg::pair_t   pair,
    output logic              res_valid,
    input  logic              res_stall,
    output aabb_pkg::result_t res
);

    logic [aabb_pkg::N_STAGES-1:0] valid_reg, valid_next;
    logic [aabb_pkg::N_STAGES:0]   ready;
    aabb_pkg::pipe_ctrl_t          ctrl;

    always_comb
    begin
        ready[aabb_pkg::N_STAGES] = !res_stall;
        for (int k = aabb_pkg::N_STAGES - 1; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        ctrl.load  = ready[aabb_pkg::N_STAGES-1:0];
        valid_next = valid_reg;
        if (ready[0]) begin
            valid_next[0] = pair_valid;
        end
        for (int k = 1; k < aabb_pkg::N_STAGES; k++) begin
            if (ready[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    aabb_core u_core (
        .clk  (clk),
        .ctrl (ctrl),
        .pair (pair),
        .res  (res)
    );

    assign pair_stall = !ready[0];
    assign res_valid  = valid_reg[aabb_pkg::N_STAGES-1];

endmodule

FILE: design/aabb_checker.sv
// ----------------------------------------------------------------------------
// aabb_checker
// Port-level checks of the collision resolver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aabb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_stall,
    input aabb_pkg::result_t res
);

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !res_valid)
    `ASSERT_CLK(a_hold_stalled, res_valid && res_stall |=> res_valid && $stable(res))
    `ASSERT_CLK(a_miss_zero, res_valid && !res.hit |-> !res.axis_vertical &&
        res.a_shift_x == '0 && res.a_shift_y == '0 && res.b_shift_x == '0 &&
        res.b_shift_y == '0 && !res.a_grounded && !res.b_grounded)
    `ASSERT_CLK(a_x_clean, res_valid && res.hit && !res.axis_vertical |->
        res.a_shift_y == '0 && res.b_shift_y == '0 && !res.a_grounded && !res.b_grounded)
    `ASSERT_CLK(a_y_ground, res_valid && res.hit && res.axis_vertical |->
        (res.a_grounded != res.b_grounded) && res.a_shift_x == '0 && res.b_shift_x == '0)

endmodule

bind aabb_collision_resolve_top aabb_checker u_aabb_checker (.*);

FILE: tb/sv/aabb_collision_resolve_top_test.sv
// ----------------------------------------------------------------------------
// aabb_collision_resolve_top_test
// Self-checking bench for the box pair collision resolver.
// Directed pairs cover gaps, touching edges, axis ties, centered boxes,
// static flags and field extremes. Random pairs are mostly placed near each
// other so that most of them hit. Both channels pause in random bursts. Each
// result is checked field by field against a local integer model of the
// resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aabb_collision_resolve_top_test;

    localparam longint CMAX = 8388607;
    localparam longint CMIN = -8388608;
    localparam longint SMAX = 1048575;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              pair_valid;
    logic              pair_stall;
    aabb_pkg::pair_t   pair;
    logic              res_valid;
    logic              res_stall = 1'b0;
    aabb_pkg::result_t res;

    bit                idling = 1'b0;
    int                stall_left = 0;
    int                cycle_count = 0;
    int                mismatches = 0;
    aabb_pkg::result_t want;
    aabb_pkg::result_t resolved_q[$];

    aabb_collision_resolve_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic aabb_pkg::shift_t clamp_shift(longint v);
        longint hi;
        longint lo;
        longint c;
        hi = (longint'(1) <<< (aabb_pkg::SHIFT_BITS - 1)) - 1;
        lo = -hi - 1;
        c = (v > hi) ? hi : ((v < lo) ? lo : v);
        return c[aabb_pkg::SHIFT_BITS-1:0];
    endfunction

    function automatic aabb_pkg::result_t resolve_pair(aabb_pkg::pair_t p);
        longint al, at, aw, ah, bl, bt, bw, bh;
        longint dx2, dy2, ovx, ovy, push, depth, a_move, b_move;
        bit vert;
        aabb_pkg::result_t r;
        r = '0;
        al = longint'(p.a_left);
        at = longint'(p.a_top);
        bl = longint'(p.b_left);
        bt = longint'(p.b_top);
        aw = longint'(p.a_width);
        ah = longint'(p.a_height);
        bw = longint'(p.b_width);
        bh = longint'(p.b_height);
        if (al + aw < bl || bl + bw < al || at + ah < bt || bt + bh < at)
        begin
            return r;
        end
        dx2 = (2 * bl + bw) - (2 * al + aw);
        dy2 = (2 * bt + bh) - (2 * at + ah);
        ovx = (aw + bw) - ((dx2 < 0) ? -dx2 : dx2);
        ovy = (ah + bh) - ((dy2 < 0) ? -dy2 : dy2);
        vert = !(ovx < ovy);
        push = vert ? dy2 : dx2;
        depth = vert ? ovy : ovx;
        if (push <= 0)
        begin
            depth = -depth;
        end
        a_move = 0;
        b_move = 0;
        case ({p.a_fixed, p.b_fixed})
            2'b00:
            begin
                a_move = -depth;
                b_move = depth;
            end
            2'b01:   a_move = -2 * depth;
            2'b10:   b_move = 2 * depth;
            default: ;
        endcase
        r.hit = 1'b1;
        r.axis_vertical = vert;
        if (vert)
        begin
            r.a_shift_y = clamp_shift(a_move);
            r.b_shift_y = clamp_shift(b_move);
            r.a_grounded = (push > 0);
            r.b_grounded = !(push > 0);
        end
        else
        begin
            r.a_shift_x = clamp_shift(a_move);
            r.b_shift_x = clamp_shift(b_move);
        end
        return r;
    endfunction

    function automatic aabb_pkg::pair_t box_pair(longint al, longint at, longint aw,
                                                 longint ah, bit af,
                                                 longint bl, longint bt, longint bw,
                                                 longint bh, bit bf);
        aabb_pkg::pair_t p;
        p.a_left   = al[aabb_pkg::COORD_BITS-1:0];
        p.a_top    = at[aabb_pkg::COORD_BITS-1:0];
        p.a_width  = aw[aabb_pkg::SIZE_BITS-1:0];
        p.a_height = ah[aabb_pkg::SIZE_BITS-1:0];
        p.a_fixed  = af;
        p.b_left   = bl[aabb_pkg::COORD_BITS-1:0];
        p.b_top    = bt[aabb_pkg::COORD_BITS-1:0];
        p.b_width  = bw[aabb_pkg::SIZE_BITS-1:0];
        p.b_height = bh[aabb_pkg::SIZE_BITS-1:0];
        p.b_fixed  = bf;
        return p;
    endfunction

    function automatic longint random_coord();
        longint c;
        case ($urandom_range(0, 6))
            4:       c = longint'($urandom_range(0, 4095)) - 2048;
            5:       c = CMAX - longint'($urandom_range(0, 2097152));
            6:       c = CMIN + longint'($urandom_range(0, 2097152));
            default: c = longint'($urandom_range(0, 24'hFFFFFF)) + CMIN;
        endcase
        return c;
    endfunction

    function automatic longint random_size();
        longint s;
        case ($urandom_range(0, 3))
            0:       s = longint'($urandom_range(0, 15));
            1:       s = longint'($urandom_range(0, 4095));
            2:       s = longint'($urandom_range(0, 20'hFFFFF));
            default: s = SMAX - longint'($urandom_range(0, 255));
        endcase
        return s;
    endfunction

    function automatic void random_span(output longint lo_a, output longint len_a,
                                        output longint lo_b, output longint len_b);
        int unsigned reach;
        len_a = random_size();
        len_b = random_size();
        lo_a = random_coord();
        reach = 32'(len_a + len_b);
        case ($urandom_range(0, 11))
            0:       lo_b = random_coord();
            1:       lo_b = lo_a + len_a;
            2:       lo_b = lo_a - len_b;
            3:       lo_b = lo_a + len_a + 1;
            4:       lo_b = lo_a - len_b - 1;
            default: lo_b = lo_a - len_b + longint'($urandom_range(0, reach));
        endcase
    endfunction

    function automatic aabb_pkg::pair_t random_pair();
        longint al, aw, bl, bw, at, ah, bt, bh;
        random_span(al, aw, bl, bw);
        if ($urandom_range(0, 7) == 0)
        begin
            ah = aw;
            bh = bw;
            at = random_coord();
            bt = at + (bl - al);
        end
        else
        begin
            random_span(at, ah, bt, bh);
        end
        return box_pair(al, at, aw, ah, 1'($urandom_range(0, 1)), bl, bt, bw, bh,
                        1'($urandom_range(0, 1)));
    endfunction

    task automatic check_field(string name, longint expected, longint actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, actual %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    task automatic send_pair(aabb_pkg::pair_t p);
        pair_valid <= 1'b1;
        pair <= p;
        do
            @(posedge clk);
        while (pair_stall);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            pair_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (resolved_q.size() == 0)
                begin
                    $error("res transfer with no pair outstanding");
                    mismatches++;
                end
                else
                begin
                    want = resolved_q.pop_front();
                    check_field("hit", longint'(want.hit), longint'(res.hit));
                    check_field("axis_vertical", longint'(want.axis_vertical),
                                longint'(res.axis_vertical));
                    check_field("a_shift_x", longint'(want.a_shift_x),
                                longint'(res.a_shift_x));
                    check_field("a_shift_y", longint'(want.a_shift_y),
                                longint'(res.a_shift_y));
                    check_field("b_shift_x", longint'(want.b_shift_x),
                                longint'(res.b_shift_x));
                    check_field("b_shift_y", longint'(want.b_shift_y),
                                longint'(res.b_shift_y));
                    check_field("a_grounded", longint'(want.a_grounded),
                                longint'(res.a_grounded));
                    check_field("b_grounded", longint'(want.b_grounded),
                                longint'(res.b_grounded));
                end
            end
            if (pair_valid && !pair_stall)
            begin
                resolved_q.insert(resolved_q.size(), resolve_pair(pair));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("aabb_collision_resolve_top regression: fail");
            $finish;
        end
    end

    task automatic test_no_contact();
        send_pair(box_pair(0, 0, 256, 256, 0, 512, 0, 256, 256, 0));
        send_pair(box_pair(0, 0, 256, 256, 0, 0, 257, 256, 256, 0));
        send_pair(box_pair(0, 0, 256, 256, 0, -1000, -1000, 999, 2000, 0));
    endtask

    task automatic test_edge_contact();
        send_pair(box_pair(0, 0, 256, 256, 0, 256, 0, 256, 256, 0));
        send_pair(box_pair(0, 0, 256, 256, 0, 0, -256, 256, 256, 0));
        send_pair(box_pair(0, 0, 256, 256, 0, 256, 256, 256, 256, 0));
        send_pair(box_pair(100, 100, 0, 0, 0, 100, 100, 0, 0, 0));
    endtask

    task automatic test_axis_choice();
        send_pair(box_pair(0, 0, 512, 512, 0, 0, 0, 512, 512, 0));
        send_pair(box_pair(0, 0, 512, 512, 0, 400, 100, 512, 300, 0));
        send_pair(box_pair(0, 0, 512, 512, 0, 100, 400, 300, 512, 0));
        send_pair(box_pair(0, 0, 512, 512, 0, 256, 256, 512, 512, 0));
        send_pair(box_pair(0, 0, 512, 512, 0, -400, 50, 512, 400, 0));
    endtask

    task automatic test_static_boxes();
        send_pair(box_pair(0, 0, 512, 512, 1, 256, 256, 512, 512, 0));
        send_pair(box_pair(0, 0, 512, 512, 0, 256, 256, 512, 512, 1));
        send_pair(box_pair(0, 0, 512, 512, 1, 256, 256, 512, 512, 1));
        send_pair(box_pair(0, 0, 512, 512, 1, -400, 50, 512, 400, 0));
    endtask

    task automatic test_field_extremes();
        send_pair(box_pair(CMIN, CMIN, SMAX, SMAX, 0, CMIN, CMIN, SMAX, SMAX, 0));
        send_pair(box_pair(CMAX, CMAX, SMAX, SMAX, 1, CMAX, CMAX, 0, 0, 0));
        send_pair(box_pair(CMIN, CMAX, 0, SMAX, 0, CMAX, CMIN, SMAX, 0, 1));
        send_pair(box_pair(-524288, -524288, SMAX, SMAX, 0, -524287, -524288, SMAX, SMAX, 0));
        send_pair(box_pair(CMAX, CMAX, SMAX, SMAX, 0, CMIN, CMIN, SMAX, SMAX, 0));
    endtask

    task automatic test_random_pairs(int count, bit with_idling);
        idling <= with_idling;
        repeat (count) send_pair(random_pair());
    endtask

    initial
    begin
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_contact();
        test_edge_contact();
        test_axis_choice();
        test_static_boxes();
        test_field_extremes();
        test_random_pairs(1100, 1'b1);
        test_random_pairs(430, 1'b0);
        pair_valid <= 1'b0;
        while (resolved_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("aabb_collision_resolve_top regression: pass");
        end
        else
        begin
            $display("aabb_collision_resolve_top regression: fail");
        end
        $finish;
    end

endmodule
